[sv/padf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padf_pkg
// Shared types and codes of the archive deframer: phases, roles, status and
// error codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package padf_pkg;

    // Largest record count that an archive may declare
    localparam int unsigned MAX_RECORDS = 4096;
    localparam int unsigned REC_CNT_W   = $clog2(MAX_RECORDS + 1);

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned NAME_LEN_W  = 16;
    localparam int unsigned BCNT_W      = 4;
    localparam int unsigned IDX_W       = 12;
    localparam int unsigned ROLE_W      = 3;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned ERR_W       = 3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = 1'b1;

    localparam logic [WORD_W-1:0] MAGIC_RESET   = 32'd0;
    localparam logic [WORD_W-1:0] VERSION_RESET = 32'd1;

    // Byte counts that bound or mark the header fields
    localparam logic [BCNT_W-1:0] FH_MAGIC_END   = 4'd4;
    localparam logic [BCNT_W-1:0] FH_VERSION_END = 4'd7;
    localparam logic [BCNT_W-1:0] FH_COUNT_END   = 4'd11;
    localparam logic [BCNT_W-1:0] RH_TYPE        = 4'd0;
    localparam logic [BCNT_W-1:0] RH_FLAGS       = 4'd1;
    localparam logic [BCNT_W-1:0] RH_LEN_START   = 4'd2;
    localparam logic [BCNT_W-1:0] RH_DATA_START  = 4'd8;
    localparam logic [BCNT_W-1:0] RH_LAST        = 4'd15;

    typedef enum logic [2:0] {
        PH_FILE = 3'd0,
        PH_REC  = 3'd1,
        PH_NAME = 3'd2,
        PH_AUX  = 3'd3,
        PH_DATA = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    localparam logic [ROLE_W-1:0] ROLE_FILE_HDR = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_REC_HDR  = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_NAME     = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_AUX      = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_DATA     = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_IGNORED  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MAGIC     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_VERSION   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TRAILING  = 3'd5;

    typedef struct packed {
        logic [WORD_W-1:0] magic_word;
        logic [WORD_W-1:0] format_version;
    } padf_cfg_t;

    typedef struct packed {
        logic [ERR_W-1:0]    error_code;
        logic [STATUS_W-1:0] status;
        logic                header_complete;
        logic [BYTE_W-1:0]   record_flags;
        logic [BYTE_W-1:0]   record_type;
        logic [IDX_W-1:0]    record_index;
        logic [ROLE_W-1:0]   byte_role;
    } padf_result_t;

endpackage

[sv/padf_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padf_cfg_regs
// Configuration register file: expected magic word and format version.
// ----------------------------------------------------------------------------
module padf_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [padf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [padf_pkg::WORD_W-1:0]         cfg_data,
    output padf_pkg::padf_cfg_t                 cfg
);

    logic [padf_pkg::WORD_W-1:0] magic_word_reg;
    logic [padf_pkg::WORD_W-1:0] format_version_reg;

    // Always able to take a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg     <= padf_pkg::MAGIC_RESET;
            format_version_reg <= padf_pkg::VERSION_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                padf_pkg::CFG_MAGIC_WORD:     magic_word_reg     <= cfg_data;
                padf_pkg::CFG_FORMAT_VERSION: format_version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.magic_word     = magic_word_reg;
    assign cfg.format_version = format_version_reg;

endmodule

[sv/padf_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padf_parser
// Archive parse state and the per-byte step: classify one byte, check the
// header fields and work out the result record.
// ----------------------------------------------------------------------------
module padf_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic [padf_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            last_byte,
    input  padf_pkg::padf_cfg_t             cfg,
    output padf_pkg::padf_result_t          result
);

    padf_pkg::phase_t                  phase_reg, phase_next;
    logic [padf_pkg::BCNT_W-1:0]       byte_count_reg, byte_count_next;
    logic [padf_pkg::LEN_W-1:0]        header_shift_reg, header_shift_next;
    logic [padf_pkg::LEN_W-1:0]        bytes_left_reg, bytes_left_next;
    logic [padf_pkg::LEN_W-1:0]        pending_data_len_reg, pending_data_len_next;
    logic [padf_pkg::REC_CNT_W-1:0]    records_total_reg, records_total_next;
    logic [padf_pkg::REC_CNT_W-1:0]    record_number_reg, record_number_next;
    logic [padf_pkg::BYTE_W-1:0]       current_type_reg, current_type_next;
    logic [padf_pkg::BYTE_W-1:0]       current_flags_reg, current_flags_next;
    logic                              failed_reg, failed_next;

    logic [padf_pkg::LEN_W-1:0]        bytes_left_dec;
    logic [padf_pkg::REC_CNT_W-1:0]    record_number_inc;
    logic [padf_pkg::NAME_LEN_W-1:0]   name_len;
    logic [padf_pkg::WORD_W-1:0]       aux_len;
    logic [padf_pkg::WORD_W-1:0]       rec_count;
    logic                              finish_rec;
    logic                              restart;
    logic [padf_pkg::BCNT_W-1:0]       k;

    assign k                 = byte_count_reg;
    assign bytes_left_dec    = bytes_left_reg - padf_pkg::LEN_W'(1);
    assign record_number_inc = record_number_reg + padf_pkg::REC_CNT_W'(1);
    assign name_len          = header_shift_next[15:0];
    assign aux_len           = header_shift_next[47:16];
    assign rec_count         = header_shift_next[63:32];

    always_comb begin
        phase_next            = phase_reg;
        byte_count_next       = byte_count_reg;
        header_shift_next     = header_shift_reg;
        bytes_left_next       = bytes_left_reg;
        pending_data_len_next = pending_data_len_reg;
        records_total_next    = records_total_reg;
        record_number_next    = record_number_reg;
        current_type_next     = current_type_reg;
        current_flags_next    = current_flags_reg;
        failed_next           = failed_reg;
        finish_rec            = 1'b0;
        restart               = 1'b0;

        result                 = '0;
        result.byte_role       = padf_pkg::ROLE_IGNORED;
        result.status          = padf_pkg::ST_BUSY;
        result.error_code      = padf_pkg::ERR_NONE;

        if (failed_reg) begin
            restart = last_byte;
        end else begin
            case (phase_reg)
                padf_pkg::PH_FILE: begin
                    result.byte_role = padf_pkg::ROLE_FILE_HDR;
                    if (k < padf_pkg::FH_MAGIC_END) begin
                        if (data_byte != cfg.magic_word[8*k[1:0] +: 8])
                            result.error_code = padf_pkg::ERR_MAGIC;
                    end else begin
                        for (int j = 0; j < 8; j++) begin
                            if (k == padf_pkg::BCNT_W'(j + 4))
                                header_shift_next[8*j +: 8] = data_byte;
                        end
                    end
                    if (result.error_code == padf_pkg::ERR_NONE &&
                        k == padf_pkg::FH_VERSION_END &&
                        header_shift_next[31:0] != cfg.format_version)
                        result.error_code = padf_pkg::ERR_VERSION;
                    if (result.error_code == padf_pkg::ERR_NONE &&
                        k == padf_pkg::FH_COUNT_END) begin
                        if (rec_count > padf_pkg::WORD_W'(padf_pkg::MAX_RECORDS)) begin
                            result.error_code = padf_pkg::ERR_TOO_MANY;
                        end else begin
                            records_total_next = padf_pkg::REC_CNT_W'(rec_count);
                            record_number_next = '0;
                            byte_count_next    = '0;
                            phase_next = (rec_count == '0) ? padf_pkg::PH_DONE
                                                           : padf_pkg::PH_REC;
                        end
                    end else begin
                        byte_count_next = k + padf_pkg::BCNT_W'(1);
                    end
                end
                padf_pkg::PH_REC: begin
                    result.byte_role = padf_pkg::ROLE_REC_HDR;
                    if (k == padf_pkg::RH_TYPE) begin
                        current_type_next  = data_byte;
                        current_flags_next = '0;
                    end else if (k == padf_pkg::RH_FLAGS) begin
                        current_flags_next = data_byte;
                    end else if (k < padf_pkg::RH_DATA_START) begin
                        for (int j = 0; j < 6; j++) begin
                            if (k == padf_pkg::BCNT_W'(j + 2))
                                header_shift_next[8*j +: 8] = data_byte;
                        end
                    end else begin
                        for (int j = 0; j < 8; j++) begin
                            if (k == padf_pkg::BCNT_W'(j + 8))
                                pending_data_len_next[8*j +: 8] = data_byte;
                        end
                    end
                    result.record_index = padf_pkg::IDX_W'(record_number_reg);
                    result.record_type  = current_type_next;
                    result.record_flags = current_flags_next;
                    if (k == padf_pkg::RH_LAST) begin
                        result.header_complete = 1'b1;
                        byte_count_next        = '0;
                        // Skip to the first part of the record that is not empty
                        if (name_len != '0) begin
                            phase_next      = padf_pkg::PH_NAME;
                            bytes_left_next = padf_pkg::LEN_W'(name_len);
                        end else if (aux_len != '0) begin
                            phase_next      = padf_pkg::PH_AUX;
                            bytes_left_next = padf_pkg::LEN_W'(aux_len);
                        end else if (pending_data_len_next != '0) begin
                            phase_next      = padf_pkg::PH_DATA;
                            bytes_left_next = pending_data_len_next;
                        end else begin
                            finish_rec = 1'b1;
                        end
                    end else begin
                        byte_count_next = k + padf_pkg::BCNT_W'(1);
                    end
                end
                padf_pkg::PH_NAME, padf_pkg::PH_AUX, padf_pkg::PH_DATA: begin
                    case (phase_reg)
                        padf_pkg::PH_NAME: result.byte_role = padf_pkg::ROLE_NAME;
                        padf_pkg::PH_AUX:  result.byte_role = padf_pkg::ROLE_AUX;
                        default:           result.byte_role = padf_pkg::ROLE_DATA;
                    endcase
                    result.record_index = padf_pkg::IDX_W'(record_number_reg);
                    result.record_type  = current_type_reg;
                    result.record_flags = current_flags_reg;
                    bytes_left_next     = bytes_left_dec;
                    if (bytes_left_dec == '0) begin
                        if (phase_reg == padf_pkg::PH_NAME && aux_len != '0) begin
                            phase_next      = padf_pkg::PH_AUX;
                            bytes_left_next = padf_pkg::LEN_W'(aux_len);
                        end else if (phase_reg != padf_pkg::PH_DATA &&
                                     pending_data_len_reg != '0) begin
                            phase_next      = padf_pkg::PH_DATA;
                            bytes_left_next = pending_data_len_reg;
                        end else begin
                            finish_rec = 1'b1;
                        end
                    end
                end
                default: begin
                    // Byte after a complete archive
                    result.byte_role  = padf_pkg::ROLE_IGNORED;
                    result.error_code = padf_pkg::ERR_TRAILING;
                end
            endcase

            if (finish_rec) begin
                record_number_next = record_number_inc;
                bytes_left_next    = '0;
                byte_count_next    = '0;
                phase_next = (record_number_inc >= records_total_reg) ? padf_pkg::PH_DONE
                                                                      : padf_pkg::PH_REC;
            end

            if (result.error_code != padf_pkg::ERR_NONE) begin
                result.status = padf_pkg::ST_REJECTED;
                if (last_byte)
                    restart = 1'b1;
                else
                    failed_next = 1'b1;
            end else if (last_byte) begin
                if (phase_next == padf_pkg::PH_DONE) begin
                    result.status = padf_pkg::ST_ACCEPTED;
                end else begin
                    result.status     = padf_pkg::ST_REJECTED;
                    result.error_code = padf_pkg::ERR_TRUNCATED;
                end
                restart = 1'b1;
            end
        end

        if (restart) begin
            phase_next         = padf_pkg::PH_FILE;
            byte_count_next    = '0;
            records_total_next = '0;
            record_number_next = '0;
            failed_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= padf_pkg::PH_FILE;
            byte_count_reg    <= '0;
            records_total_reg <= '0;
            record_number_reg <= '0;
            failed_reg        <= 1'b0;
        end else if (step_en) begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            records_total_reg <= records_total_next;
            record_number_reg <= record_number_next;
            failed_reg        <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            header_shift_reg     <= header_shift_next;
            bytes_left_reg       <= bytes_left_next;
            pending_data_len_reg <= pending_data_len_next;
            current_type_reg     <= current_type_next;
            current_flags_reg    <= current_flags_next;
        end
    end

`ifndef ASSERT_OFF
    a_reject_sets_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.status == padf_pkg::ST_REJECTED && !last_byte)
        |=> failed_reg)
        else $error("rejected byte did not enter the failed state");

    a_hc_only_rec_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.header_complete)
        |-> (result.byte_role == padf_pkg::ROLE_REC_HDR && k == padf_pkg::RH_LAST))
        else $error("header complete outside record header byte 15");

    a_record_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (!failed_reg && (phase_reg == padf_pkg::PH_REC || phase_reg == padf_pkg::PH_NAME ||
         phase_reg == padf_pkg::PH_AUX || phase_reg == padf_pkg::PH_DATA))
        |-> (record_number_reg < records_total_reg))
        else $error("record number beyond declared record count");
`endif

endmodule

[sv/patch_archive_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_archive_deframer
// Byte-stream archive deframer: tags every byte with its role and record,
// checks magic, version and record count, and reports accept or reject.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports         | Item
//  ---------+---------------+------------------------------------------------
//  input    | s_axis_*      | one archive byte, tlast on the final byte
//  result   | m_axis_*      | role in tuser, index/type/flags/status in tdata
//  config   | cfg_*         | register write: index 0 magic, 1 version
//
//  One item per cycle while the result does not stall. An accepted byte is
//  captured in the input register and parsed into the result register by
//  the next parse step, after which the result is valid for the consumer.
//  The parse step is a single pass of counter compares and byte-lane
//  captures; the 64-bit down-count of the current part is the longest
//  path. Reset clears parse state and restores the register defaults. A
//  stalled result holds the input register, which still takes a new byte
//  when the result is taken in the same cycle.
//
module patch_archive_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
    input  logic                                s_axis_tlast,  // last_byte

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] record_index, [19:12] record_type, [27:20] record_flags,
    // [28] header_complete, [30:29] status, [33:31] error_code, [39:34] zero
    output logic [39:0]                         m_axis_tdata,
    output logic [2:0]                          m_axis_tuser,  // [2:0] byte_role

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [padf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [padf_pkg::WORD_W-1:0]         cfg_data
);

    padf_pkg::padf_cfg_t                cfg;
    padf_pkg::padf_result_t             step_result;
    padf_pkg::padf_result_t             out_result_reg;

    logic                               in_vld_reg;
    logic [padf_pkg::BYTE_W-1:0]        in_byte_reg;
    logic                               in_last_reg;
    logic                               out_vld_reg;
    logic                               step_fire;

    // Advance the held byte whenever the result register is free or draining
    assign step_fire     = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || step_fire;

    padf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    padf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_fire),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    // Input register: capture a byte on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Result register: load on a parse step, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step_fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_result_reg.byte_role;
    assign m_axis_tdata  = {6'b0,
                            out_result_reg.error_code,
                            out_result_reg.status,
                            out_result_reg.header_complete,
                            out_result_reg.record_flags,
                            out_result_reg.record_type,
                            out_result_reg.record_index};

`ifndef ASSERT_OFF
    a_step_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> out_vld_reg)
        else $error("parse step did not load the result register");

    a_no_step_without_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_axis_tready) |-> !step_fire)
        else $error("parse step overwrote a stalled result");

    a_hold_byte_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !step_fire) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("held input byte lost while the result stalled");
`endif

endmodule
